// ===== rtl/core/ptbs_pkg.sv =====
// ----------------------------------------------------------------------------
// ptbs_pkg
// Shared types, codes and helpers for the peer table best-select block.
// ----------------------------------------------------------------------------
package ptbs_pkg;

    localparam int HOST_W   = 64;
    localparam int PORT_W   = 16;
    localparam int LAT_W    = 16;
    localparam int CAP_W    = 8;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [CAP_W-1:0] CAP_BASE = 8'd1;
    localparam logic [CAP_W-1:0] CAP_FULL = 8'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_MSCAN,
        S_BSCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [HOST_W-1:0] host;
        logic [PORT_W-1:0] port;
        logic [LAT_W-1:0]  lat;
        logic [CAP_W-1:0]  cap;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic    capture;
        logic    clear_cnt;
        logic    scan_start;
        logic    scan_step;
        logic    best_en;
        logic    write_hit;
        logic    write_append;
        logic    set_status;
        t_status status;
        logic    out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic op_clear;
        logic item_ok;
        logic hit;
        logic scan_done;
        logic full;
    } t_sts;

    // zero every byte after the first zero byte, counting from the top
    function automatic logic [HOST_W-1:0] canon_key(input logic [HOST_W-1:0] key);
        logic [HOST_W-1:0] k;
        logic              alive;
        k     = '0;
        alive = 1'b1;
        for (int b = 7; b >= 0; b--) begin
            if (key[b*8 +: 8] == 8'h00) begin
                alive = 1'b0;
            end
            if (alive) begin
                k[b*8 +: 8] = key[b*8 +: 8];
            end
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/peer_table_best_select.sv =====
// ----------------------------------------------------------------------------
// peer_table_best_select
// Peer table with add/update/clear and lowest-latency best-peer report.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   op 0 adds or updates a peer, op 1 empties the table. Each transaction
//   gives one result, shown for one cycle with o_valid high: status, entry
//   count and the best entry (lowest latency, then smaller host key, then
//   smaller port), all zero with o_best_valid low when the table is empty.
//   An add runs a match scan and then a best scan, each reading one entry
//   per cycle through the registered read port of the entry RAM; a clear
//   runs neither scan, an update ends the match scan at the hit and an
//   invalid peer skips it. busy drops in the cycle o_valid is shown, so
//   the next transaction may start then.
//   The receiver cannot stall; o_valid is shown once and not held.
//   Reset (synchronous, active low) empties the table and returns to idle;
//   entry contents are not cleared, only the count.
// ----------------------------------------------------------------------------
module peer_table_best_select #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [ptbs_pkg::HOST_W-1:0]   i_host_key,
    input  logic [ptbs_pkg::PORT_W-1:0]   i_peer_port,
    input  logic [ptbs_pkg::LAT_W-1:0]    i_latency,
    input  logic [ptbs_pkg::CAP_W-1:0]    i_capability_bits,
    output logic                          o_valid,
    output logic [ptbs_pkg::STATUS_W-1:0] o_status,
    output logic [ptbs_pkg::COUNT_W-1:0]  o_entry_count,
    output logic                          o_best_valid,
    output logic [ptbs_pkg::HOST_W-1:0]   o_best_host,
    output logic [ptbs_pkg::PORT_W-1:0]   o_best_port,
    output logic [ptbs_pkg::LAT_W-1:0]    o_best_latency,
    output logic [ptbs_pkg::CAP_W-1:0]    o_best_capabilities
);

    ptbs_pkg::t_cmd w_cmd;
    ptbs_pkg::t_sts w_sts;

    ptbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ptbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_op                (i_op),
        .i_host_key          (i_host_key),
        .i_peer_port         (i_peer_port),
        .i_latency           (i_latency),
        .i_capability_bits   (i_capability_bits),
        .o_status            (o_status),
        .o_entry_count       (o_entry_count),
        .o_best_valid        (o_best_valid),
        .o_best_host         (o_best_host),
        .o_best_port         (o_best_port),
        .o_best_latency      (o_best_latency),
        .o_best_capabilities (o_best_capabilities)
    );

endmodule

// ===== rtl/core/ptbs_ram.sv =====
// ----------------------------------------------------------------------------
// ptbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptbs_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/ptbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptbs_ctrl
// Sequencer: validate, match scan, write, best scan, report; or clear and report.
// ----------------------------------------------------------------------------
module ptbs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output logic             o_valid,
    input  ptbs_pkg::t_sts   i_sts,
    output ptbs_pkg::t_cmd   o_cmd
);

    ptbs_pkg::t_state r_state;
    ptbs_pkg::t_state n_state;
    logic             r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptbs_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ptbs_pkg::S_DONE);
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = ptbs_pkg::ST_OK;
        busy    = 1'b1;
        case (r_state)
            ptbs_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ptbs_pkg::S_DECIDE;
                end
            end
            ptbs_pkg::S_DECIDE: begin
                if (i_sts.op_clear) begin
                    o_cmd.clear_cnt = 1'b1;
                    n_state         = ptbs_pkg::S_DONE;
                end else if (!i_sts.item_ok) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ptbs_pkg::ST_INVALID;
                    o_cmd.scan_start = 1'b1;
                    n_state          = ptbs_pkg::S_BSCAN;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ptbs_pkg::S_MSCAN;
                end
            end
            ptbs_pkg::S_MSCAN: begin
                if (i_sts.hit) begin
                    o_cmd.write_hit  = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = ptbs_pkg::S_BSCAN;
                end else if (i_sts.scan_done) begin
                    // no match: append unless the table is full
                    if (i_sts.full) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ptbs_pkg::ST_FULL;
                    end else begin
                        o_cmd.write_append = 1'b1;
                    end
                    o_cmd.scan_start = 1'b1;
                    n_state          = ptbs_pkg::S_BSCAN;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ptbs_pkg::S_BSCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ptbs_pkg::S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    o_cmd.best_en   = 1'b1;
                end
            end
            ptbs_pkg::S_DONE: begin
                o_cmd.out_load = 1'b1;
                n_state        = ptbs_pkg::S_IDLE;
            end
            default: begin
                n_state = ptbs_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid = r_done;

endmodule

// ===== rtl/core/ptbs_dp.sv =====
// ----------------------------------------------------------------------------
// ptbs_dp
// Datapath: item registers, entry table, pipelined scan and best tracking.
// ----------------------------------------------------------------------------
module ptbs_dp #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ptbs_pkg::t_cmd                   i_cmd,
    output ptbs_pkg::t_sts                   o_sts,
    input  logic                             i_op,
    input  logic [ptbs_pkg::HOST_W-1:0]      i_host_key,
    input  logic [ptbs_pkg::PORT_W-1:0]      i_peer_port,
    input  logic [ptbs_pkg::LAT_W-1:0]       i_latency,
    input  logic [ptbs_pkg::CAP_W-1:0]       i_capability_bits,
    output logic [ptbs_pkg::STATUS_W-1:0]    o_status,
    output logic [ptbs_pkg::COUNT_W-1:0]     o_entry_count,
    output logic                             o_best_valid,
    output logic [ptbs_pkg::HOST_W-1:0]      o_best_host,
    output logic [ptbs_pkg::PORT_W-1:0]      o_best_port,
    output logic [ptbs_pkg::LAT_W-1:0]       o_best_latency,
    output logic [ptbs_pkg::CAP_W-1:0]       o_best_capabilities
);

    localparam int IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int OCW   = ptbs_pkg::COUNT_W;
    localparam int ENT_W = $bits(ptbs_pkg::t_entry);

    // current transaction
    logic                          r_op;
    ptbs_pkg::t_entry              r_item;
    ptbs_pkg::t_status             r_status;

    logic [CW-1:0]                 r_cnt;
    logic [CW-1:0]                 r_idx;
    logic                          r_pv;
    logic [IW-1:0]                 r_pidx;
    ptbs_pkg::t_entry              r_best;
    logic                          r_best_valid;

    logic [ptbs_pkg::STATUS_W-1:0] r_o_status;
    logic [OCW-1:0]                r_o_count;
    logic                          r_o_best_valid;
    ptbs_pkg::t_entry              r_o_best;

    ptbs_pkg::t_entry              w_rd;
    logic [ENT_W-1:0]              w_rd_raw;
    logic                          w_issue;
    logic                          w_beats;
    logic                          w_wr_en;
    logic [IW-1:0]                 w_wr_addr;

    assign w_issue   = i_cmd.scan_step && (r_idx != r_cnt);
    assign w_wr_en   = i_cmd.write_hit || i_cmd.write_append;
    assign w_wr_addr = i_cmd.write_hit ? r_pidx : r_cnt[IW-1:0];

    ptbs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_item),
        .i_rd_addr (r_idx[IW-1:0]),
        .o_rd_data (w_rd_raw)
    );

    assign w_rd = w_rd_raw;

    // lowest latency, then smaller host key, then smaller port
    always_comb begin
        if (w_rd.lat != r_best.lat) begin
            w_beats = w_rd.lat < r_best.lat;
        end else if (w_rd.host != r_best.host) begin
            w_beats = w_rd.host < r_best.host;
        end else begin
            w_beats = w_rd.port < r_best.port;
        end
    end

    always_comb begin
        o_sts.op_clear  = r_op;
        o_sts.item_ok   = (r_item.host[ptbs_pkg::HOST_W-1 -: 8] != 8'h00) &&
                          (r_item.port != '0) &&
                          ((r_item.cap == ptbs_pkg::CAP_BASE) ||
                           (r_item.cap == ptbs_pkg::CAP_FULL));
        o_sts.hit       = r_pv && (w_rd.host == r_item.host) &&
                          (w_rd.port == r_item.port);
        o_sts.scan_done = !r_pv && (r_idx == r_cnt);
        o_sts.full      = (r_cnt == CW'(TABLE_DEPTH));
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= i_op;
            r_item.host <= ptbs_pkg::canon_key(i_host_key);
            r_item.port <= i_peer_port;
            r_item.lat  <= i_latency;
            r_item.cap  <= i_capability_bits;
        end
        if (w_issue) begin
            r_pidx <= r_idx[IW-1:0];
        end
        if (i_cmd.capture) begin
            r_best <= '0;
        end else if (i_cmd.best_en && r_pv && (!r_best_valid || w_beats)) begin
            r_best <= w_rd;
        end
        if (i_cmd.out_load) begin
            r_o_status     <= r_status;
            r_o_count      <= OCW'(r_cnt);
            r_o_best_valid <= r_best_valid;
            r_o_best       <= r_best;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status     <= ptbs_pkg::ST_OK;
            r_cnt        <= '0;
            r_idx        <= '0;
            r_pv         <= 1'b0;
            r_best_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_status <= ptbs_pkg::ST_OK;
            end else if (i_cmd.set_status) begin
                r_status <= i_cmd.status;
            end

            if (i_cmd.clear_cnt) begin
                r_cnt <= '0;
            end else if (i_cmd.write_append) begin
                r_cnt <= r_cnt + CW'(1);
            end

            if (i_cmd.scan_start) begin
                r_idx <= '0;
                r_pv  <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_pv <= w_issue;
                if (w_issue) begin
                    r_idx <= r_idx + CW'(1);
                end
            end

            if (i_cmd.capture) begin
                r_best_valid <= 1'b0;
            end else if (i_cmd.best_en && r_pv) begin
                r_best_valid <= 1'b1;
            end
        end
    end

    assign o_status            = r_o_status;
    assign o_entry_count       = r_o_count;
    assign o_best_valid        = r_o_best_valid;
    assign o_best_host         = r_o_best.host;
    assign o_best_port         = r_o_best.port;
    assign o_best_latency      = r_o_best.lat;
    assign o_best_capabilities = r_o_best.cap;

endmodule

// ===== rtl/core/ptbs_chk.sv =====
// ----------------------------------------------------------------------------
// ptbs_chk
// Port-level checks for the peer table best-select block.
// ----------------------------------------------------------------------------
module ptbs_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic [ptbs_pkg::STATUS_W-1:0] o_status,
    input logic                          o_best_valid,
    input logic [ptbs_pkg::HOST_W-1:0]   o_best_host,
    input logic [ptbs_pkg::PORT_W-1:0]   o_best_port,
    input logic [ptbs_pkg::LAT_W-1:0]    o_best_latency,
    input logic [ptbs_pkg::CAP_W-1:0]    o_best_capabilities
);

    // a taken transaction occupies the block
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after a transaction was taken");

    // the result appears exactly when the block frees up
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    // each result strobe lasts a single cycle
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // empty table reports zero best fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_best_valid |-> (o_best_host == '0) && (o_best_port == '0) &&
        (o_best_latency == '0) && (o_best_capabilities == '0))
        else $error("best fields not zero on an empty table");

    // status is one of the defined codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ptbs_pkg::ST_OK) || (o_status == ptbs_pkg::ST_INVALID) ||
        (o_status == ptbs_pkg::ST_FULL))
        else $error("undefined status code");

endmodule

bind peer_table_best_select ptbs_chk u_ptbs_chk (.*);
